// File: src/rv32i_instruction_decoder_macros.svh
// Assertion macros for the RV32I instruction decoder RTL.
`ifndef RV32I_INSTRUCTION_DECODER_MACROS_SVH
`define RV32I_INSTRUCTION_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define RVID_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RVID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVID_ASSERT(lbl, clk, rst, prop, msg)
`define RVID_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/rvid_pkg.sv
// Package with opcodes, operation numbers and the decode result type.
package rvid_pkg;

   localparam logic [6:0] OpcLui    = 7'h37;
   localparam logic [6:0] OpcAuipc  = 7'h17;
   localparam logic [6:0] OpcJal    = 7'h6F;
   localparam logic [6:0] OpcJalr   = 7'h67;
   localparam logic [6:0] OpcBranch = 7'h63;
   localparam logic [6:0] OpcLoad   = 7'h03;
   localparam logic [6:0] OpcStore  = 7'h23;
   localparam logic [6:0] OpcOpImm  = 7'h13;
   localparam logic [6:0] OpcOp     = 7'h33;
   localparam logic [6:0] OpcSystem = 7'h73;

   localparam logic [6:0] F7Zero = 7'h00;
   localparam logic [6:0] F7Alt  = 7'h20;

   localparam logic [5:0] OpLui   = 6'd0;
   localparam logic [5:0] OpAuipc = 6'd1;
   localparam logic [5:0] OpJal   = 6'd2;
   localparam logic [5:0] OpJalr  = 6'd3;
   localparam logic [5:0] OpBeq   = 6'd4;
   localparam logic [5:0] OpBne   = 6'd5;
   localparam logic [5:0] OpBlt   = 6'd6;
   localparam logic [5:0] OpBge   = 6'd7;
   localparam logic [5:0] OpBltu  = 6'd8;
   localparam logic [5:0] OpBgeu  = 6'd9;
   localparam logic [5:0] OpLb    = 6'd10;
   localparam logic [5:0] OpLh    = 6'd11;
   localparam logic [5:0] OpLw    = 6'd12;
   localparam logic [5:0] OpLbu   = 6'd13;
   localparam logic [5:0] OpLhu   = 6'd14;
   localparam logic [5:0] OpSb    = 6'd15;
   localparam logic [5:0] OpSh    = 6'd16;
   localparam logic [5:0] OpSw    = 6'd17;
   localparam logic [5:0] OpAddi  = 6'd18;
   localparam logic [5:0] OpSlti  = 6'd19;
   localparam logic [5:0] OpSltiu = 6'd20;
   localparam logic [5:0] OpXori  = 6'd21;
   localparam logic [5:0] OpOri   = 6'd22;
   localparam logic [5:0] OpAndi  = 6'd23;
   localparam logic [5:0] OpSlli  = 6'd24;
   localparam logic [5:0] OpSrli  = 6'd25;
   localparam logic [5:0] OpSrai  = 6'd26;
   localparam logic [5:0] OpAdd   = 6'd27;
   localparam logic [5:0] OpSub   = 6'd28;
   localparam logic [5:0] OpSll   = 6'd29;
   localparam logic [5:0] OpSlt   = 6'd30;
   localparam logic [5:0] OpSltu  = 6'd31;
   localparam logic [5:0] OpXor   = 6'd32;
   localparam logic [5:0] OpSrl   = 6'd33;
   localparam logic [5:0] OpSra   = 6'd34;
   localparam logic [5:0] OpOr    = 6'd35;
   localparam logic [5:0] OpAnd   = 6'd36;

   typedef struct packed {
      logic [5:0]         op_class;
      logic               illegal;
      logic [4:0]         dest_index;
      logic               writes_dest;
      logic [4:0]         src1_index;
      logic               reads_src1;
      logic [4:0]         src2_index;
      logic               reads_src2;
      logic signed [31:0] immediate;
      logic               ends_block;
   } rvid_result_type;

endpackage

// File: src/rvid_decode.sv
// Combinational decode of one RV32I instruction word into a result beat.
module rvid_decode
   import rvid_pkg::*;
(
   input  logic [31:0]     instr_word,
   output rvid_result_type result
);

   logic [6:0]  opcode;
   logic [2:0]  funct3;
   logic [6:0]  funct7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_j;
   logic [31:0] imm_u;
   logic        ok;
   logic [5:0]  op;
   logic [31:0] imm;
   logic        wd;
   logic        r1;
   logic        r2;
   logic        endb;

   assign opcode = instr_word[6:0];
   assign funct3 = instr_word[14:12];
   assign funct7 = instr_word[31:25];

   assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
   assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
   assign imm_b = {{20{instr_word[31]}}, instr_word[7], instr_word[30:25],
                   instr_word[11:8], 1'b0};
   assign imm_j = {{12{instr_word[31]}}, instr_word[19:12], instr_word[20],
                   instr_word[30:21], 1'b0};
   assign imm_u = {instr_word[31:12], 12'h000};

   always_comb begin
      ok   = 1'b1;
      op   = OpLui;
      imm  = 32'h0;
      wd   = 1'b0;
      r1   = 1'b0;
      r2   = 1'b0;
      endb = 1'b0;
      unique case (opcode)
         OpcLui: begin
            op  = OpLui;
            wd  = 1'b1;
            imm = imm_u;
         end
         OpcAuipc: begin
            op  = OpAuipc;
            wd  = 1'b1;
            imm = imm_u;
         end
         OpcJal: begin
            op   = OpJal;
            wd   = 1'b1;
            imm  = imm_j;
            endb = 1'b1;
         end
         OpcJalr: begin
            op   = OpJalr;
            wd   = 1'b1;
            r1   = 1'b1;
            imm  = imm_i;
            endb = 1'b1;
            ok   = (funct3 == 3'd0);
         end
         OpcBranch: begin
            r1   = 1'b1;
            r2   = 1'b1;
            imm  = imm_b;
            endb = 1'b1;
            unique case (funct3)
               3'd0: op = OpBeq;
               3'd1: op = OpBne;
               3'd4: op = OpBlt;
               3'd5: op = OpBge;
               3'd6: op = OpBltu;
               3'd7: op = OpBgeu;
               default: ok = 1'b0;
            endcase
         end
         OpcLoad: begin
            wd  = 1'b1;
            r1  = 1'b1;
            imm = imm_i;
            unique case (funct3)
               3'd0: op = OpLb;
               3'd1: op = OpLh;
               3'd2: op = OpLw;
               3'd4: op = OpLbu;
               3'd5: op = OpLhu;
               default: ok = 1'b0;
            endcase
         end
         OpcStore: begin
            r1  = 1'b1;
            r2  = 1'b1;
            imm = imm_s;
            unique case (funct3)
               3'd0: op = OpSb;
               3'd1: op = OpSh;
               3'd2: op = OpSw;
               default: ok = 1'b0;
            endcase
         end
         OpcOpImm: begin
            wd  = 1'b1;
            r1  = 1'b1;
            imm = imm_i;
            unique case (funct3)
               3'd0: op = OpAddi;
               3'd1: begin
                  op = OpSlli;
                  ok = (funct7 == F7Zero);
               end
               3'd2: op = OpSlti;
               3'd3: op = OpSltiu;
               3'd4: op = OpXori;
               3'd5: begin
                  if (funct7 == F7Alt) begin
                     op = OpSrai;
                  end else begin
                     op = OpSrli;
                     ok = (funct7 == F7Zero);
                  end
               end
               3'd6: op = OpOri;
               3'd7: op = OpAndi;
               default: ok = 1'b0;
            endcase
         end
         OpcOp: begin
            wd = 1'b1;
            r1 = 1'b1;
            r2 = 1'b1;
            unique case (funct3)
               3'd0: op = (funct7 == F7Alt) ? OpSub : OpAdd;
               3'd1: begin
                  op = OpSll;
                  ok = (funct7 == F7Zero);
               end
               3'd2: op = OpSlt;
               3'd3: op = OpSltu;
               3'd4: op = OpXor;
               3'd5: begin
                  if (funct7 == F7Alt) begin
                     op = OpSra;
                  end else begin
                     op = OpSrl;
                     ok = (funct7 == F7Zero);
                  end
               end
               3'd6: op = OpOr;
               3'd7: op = OpAnd;
               default: ok = 1'b0;
            endcase
         end
         OpcSystem: begin
            endb = 1'b1;
            ok   = 1'b0;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      result.op_class    = ok ? op : OpLui;
      result.illegal     = ~ok;
      result.dest_index  = instr_word[11:7];
      result.writes_dest = ok & wd;
      result.src1_index  = instr_word[19:15];
      result.reads_src1  = ok & r1;
      result.src2_index  = instr_word[24:20];
      result.reads_src2  = ok & r2;
      result.immediate   = ok ? $signed(imm) : 32'sh0;
      result.ends_block  = endb;
   end

endmodule

// File: src/rv32i_instruction_decoder.sv
// Top level of the RV32I instruction decoder: input register, decode, result register.
//
//  Channel | Handshake             | Payload
//  req     | start, busy           | req_instr_word
//  rsp     | rsp_valid (strobe)    | rsp_op_class ... rsp_ends_block
//
//  Every instruction word gives exactly one result beat, through the input register and then the result register.
//  A new word is taken in every cycle; busy is always low, since the two register
//  stages move on every clock and the result receiver cannot stall.
//  Synchronous reset clears the valid bits of both stages; payload is not reset.
`include "rv32i_instruction_decoder_macros.svh"
module rv32i_instruction_decoder
   import rvid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_instr_word,
   output logic               rsp_valid,
   output logic [5:0]         rsp_op_class,
   output logic               rsp_illegal,
   output logic [4:0]         rsp_dest_index,
   output logic               rsp_writes_dest,
   output logic [4:0]         rsp_src1_index,
   output logic               rsp_reads_src1,
   output logic [4:0]         rsp_src2_index,
   output logic               rsp_reads_src2,
   output logic signed [31:0] rsp_immediate,
   output logic               rsp_ends_block
);

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [31:0]     in_word_ff;
   logic [31:0]     in_word_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   rvid_result_type out_result_ff;
   rvid_result_type out_result_in;
   rvid_result_type decoded;

   assign busy        = 1'b0;
   assign in_valid_in = start & ~busy;
   assign in_word_in  = req_instr_word;

   rvid_decode u_decode (
      .instr_word (in_word_ff),
      .result     (decoded)
   );

   assign out_valid_in  = in_valid_ff;
   assign out_result_in = decoded;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff    <= in_word_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_op_class    = out_result_ff.op_class;
   assign rsp_illegal     = out_result_ff.illegal;
   assign rsp_dest_index  = out_result_ff.dest_index;
   assign rsp_writes_dest = out_result_ff.writes_dest;
   assign rsp_src1_index  = out_result_ff.src1_index;
   assign rsp_reads_src1  = out_result_ff.reads_src1;
   assign rsp_src2_index  = out_result_ff.src2_index;
   assign rsp_reads_src2  = out_result_ff.reads_src2;
   assign rsp_immediate   = out_result_ff.immediate;
   assign rsp_ends_block  = out_result_ff.ends_block;

   `RVID_ASSERT(a_beat_latency, clock, reset, (start && !busy) |-> ##2 rsp_valid, "accepted word gave no result beat")
   `RVID_ASSERT(a_no_spurious, clock, reset, rsp_valid |-> $past(start, 2), "result beat without accepted word")
   `RVID_ASSERT(a_illegal_clean, clock, reset, (rsp_valid && rsp_illegal) |-> (rsp_op_class == OpLui && !rsp_writes_dest && !rsp_reads_src1 && !rsp_reads_src2 && rsp_immediate == 32'sh0), "illegal beat carries decode data")
   `RVID_ASSERT(a_op_range, clock, reset, rsp_valid |-> (rsp_op_class <= OpAnd), "operation number out of range")
   `RVID_ASSERT_ALWAYS(a_never_busy, clock, !busy, "decoder reported busy")

endmodule

// File: tb/sv/rv32i_instruction_decoder_tb.sv
// Self-checking testbench for the RV32I instruction decoder: directed table, then random words.
module rv32i_instruction_decoder_tb
   import rvid_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         ClockPeriod   = 12;
   localparam int         ResetCycles   = 6;
   localparam int         WatchdogLimit = 1000;
   localparam int         DrainCycles   = 10;
   localparam int         RandomWords   = 1700;
   localparam int         MaxReported   = 10;
   localparam logic [6:0] OpcMiscMem    = 7'h0F;

   localparam logic [10:0][6:0] KnownOpcodes = {
      OpcMiscMem, OpcSystem, OpcOp, OpcOpImm, OpcStore, OpcLoad,
      OpcBranch, OpcJalr, OpcJal, OpcAuipc, OpcLui
   };

   localparam logic [7:0][5:0] BranchOps = {
      OpBgeu, OpBltu, OpBge, OpBlt, OpLui, OpLui, OpBne, OpBeq
   };
   localparam logic [7:0]      BranchF3Ok = 8'b1111_0011;
   localparam logic [7:0][5:0] LoadOps = {
      OpLui, OpLui, OpLhu, OpLbu, OpLui, OpLw, OpLh, OpLb
   };
   localparam logic [7:0]      LoadF3Ok = 8'b0011_0111;
   localparam logic [7:0][5:0] StoreOps = {
      OpLui, OpLui, OpLui, OpLui, OpLui, OpSw, OpSh, OpSb
   };
   localparam logic [7:0]      StoreF3Ok = 8'b0000_0111;
   localparam logic [7:0][5:0] ImmAluOps = {
      OpAndi, OpOri, OpSrli, OpXori, OpSltiu, OpSlti, OpSlli, OpAddi
   };
   localparam logic [7:0][5:0] RegAluOps = {
      OpAnd, OpOr, OpSrl, OpXor, OpSltu, OpSlt, OpSll, OpAdd
   };

   typedef struct packed {
      logic [31:0]     word;
      logic            typed;
      rvid_result_type want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [31:0]        req_instr_word = '0;
   logic               rsp_valid;
   logic [5:0]         rsp_op_class;
   logic               rsp_illegal;
   logic [4:0]         rsp_dest_index;
   logic               rsp_writes_dest;
   logic [4:0]         rsp_src1_index;
   logic               rsp_reads_src1;
   logic [4:0]         rsp_src2_index;
   logic               rsp_reads_src2;
   logic signed [31:0] rsp_immediate;
   logic               rsp_ends_block;

   rvid_result_type expected_decodes [$];
   stim_row_type    directed_rows [$];
   int              error_count = 0;
   int              quiet_cycles = 0;
   int              burst_left = 0;

   rv32i_instruction_decoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_instr_word  (req_instr_word),
      .rsp_valid       (rsp_valid),
      .rsp_op_class    (rsp_op_class),
      .rsp_illegal     (rsp_illegal),
      .rsp_dest_index  (rsp_dest_index),
      .rsp_writes_dest (rsp_writes_dest),
      .rsp_src1_index  (rsp_src1_index),
      .rsp_reads_src1  (rsp_reads_src1),
      .rsp_src2_index  (rsp_src2_index),
      .rsp_reads_src2  (rsp_reads_src2),
      .rsp_immediate   (rsp_immediate),
      .rsp_ends_block  (rsp_ends_block)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   function automatic rvid_result_type decode_word(input logic [31:0] w);
      logic [6:0]      opc;
      logic [2:0]      f3;
      logic [6:0]      f7;
      logic [31:0]     imm_i;
      logic [31:0]     imm_s;
      logic [31:0]     imm_b;
      logic [31:0]     imm_j;
      logic            ok;
      logic [5:0]      op;
      logic            wd;
      logic            r1;
      logic            r2;
      logic            endb;
      logic [31:0]     imm;
      rvid_result_type r;
      opc   = w[6:0];
      f3    = w[14:12];
      f7    = w[31:25];
      imm_i = {{20{w[31]}}, w[31:20]};
      imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      ok    = 1'b1;
      op    = OpLui;
      wd    = 1'b0;
      r1    = 1'b0;
      r2    = 1'b0;
      endb  = 1'b0;
      imm   = '0;
      case (opc)
         OpcLui: begin
            op  = OpLui;
            wd  = 1'b1;
            imm = {w[31:12], 12'b0};
         end
         OpcAuipc: begin
            op  = OpAuipc;
            wd  = 1'b1;
            imm = {w[31:12], 12'b0};
         end
         OpcJal: begin
            op   = OpJal;
            wd   = 1'b1;
            imm  = imm_j;
            endb = 1'b1;
         end
         OpcJalr: begin
            op   = OpJalr;
            wd   = 1'b1;
            r1   = 1'b1;
            imm  = imm_i;
            endb = 1'b1;
            ok   = (f3 == '0);
         end
         OpcBranch: begin
            op   = BranchOps[f3];
            r1   = 1'b1;
            r2   = 1'b1;
            imm  = imm_b;
            endb = 1'b1;
            ok   = BranchF3Ok[f3];
         end
         OpcLoad: begin
            op  = LoadOps[f3];
            wd  = 1'b1;
            r1  = 1'b1;
            imm = imm_i;
            ok  = LoadF3Ok[f3];
         end
         OpcStore: begin
            op  = StoreOps[f3];
            r1  = 1'b1;
            r2  = 1'b1;
            imm = imm_s;
            ok  = StoreF3Ok[f3];
         end
         OpcOpImm: begin
            op  = ImmAluOps[f3];
            wd  = 1'b1;
            r1  = 1'b1;
            imm = imm_i;
            if (op == OpSlli) begin
               ok = (f7 == F7Zero);
            end else if (op == OpSrli) begin
               if (f7 == F7Alt) op = OpSrai;
               else ok = (f7 == F7Zero);
            end
         end
         OpcOp: begin
            op = RegAluOps[f3];
            wd = 1'b1;
            r1 = 1'b1;
            r2 = 1'b1;
            if (op == OpAdd) begin
               if (f7 == F7Alt) op = OpSub;
            end else if (op == OpSll) begin
               ok = (f7 == F7Zero);
            end else if (op == OpSrl) begin
               if (f7 == F7Alt) op = OpSra;
               else ok = (f7 == F7Zero);
            end
         end
         OpcSystem: begin
            endb = 1'b1;
            ok   = 1'b0;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      if (!ok) begin
         op  = OpLui;
         wd  = 1'b0;
         r1  = 1'b0;
         r2  = 1'b0;
         imm = '0;
      end
      r.op_class    = op;
      r.illegal     = !ok;
      r.dest_index  = w[11:7];
      r.writes_dest = wd;
      r.src1_index  = w[19:15];
      r.reads_src1  = r1;
      r.src2_index  = w[24:20];
      r.reads_src2  = r2;
      r.immediate   = imm;
      r.ends_block  = endb;
      return r;
   endfunction

   // Mostly well-formed words with random fields, the rest raw noise.
   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(0, 99) < 85) begin
         w[6:0] = KnownOpcodes[$urandom_range(0, 10)];
         if ((w[6:0] == OpcOp || w[6:0] == OpcOpImm) && $urandom_range(0, 3) != 0)
            w[31:25] = $urandom_range(0, 1) ? F7Alt : F7Zero;
         if (w[6:0] == OpcJalr && $urandom_range(0, 1))
            w[14:12] = '0;
      end
      return w;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MaxReported)
            $display("Mismatch in %s: expected 0x%08h, got 0x%08h", name, want, got);
      end
   endtask

   task automatic compare_decode(input rvid_result_type want, input rvid_result_type got);
      check_field("op_class", 32'(want.op_class), 32'(got.op_class));
      check_field("illegal", 32'(want.illegal), 32'(got.illegal));
      check_field("dest_index", 32'(want.dest_index), 32'(got.dest_index));
      check_field("writes_dest", 32'(want.writes_dest), 32'(got.writes_dest));
      check_field("src1_index", 32'(want.src1_index), 32'(got.src1_index));
      check_field("reads_src1", 32'(want.reads_src1), 32'(got.reads_src1));
      check_field("src2_index", 32'(want.src2_index), 32'(got.src2_index));
      check_field("reads_src2", 32'(want.reads_src2), 32'(got.reads_src2));
      check_field("immediate", want.immediate, got.immediate);
      check_field("ends_block", 32'(want.ends_block), 32'(got.ends_block));
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         start          <= 1'b0;
         req_instr_word <= $urandom;
         @(posedge clock);
      end
   endtask

   task automatic pace_sender();
      int r;
      burst_left--;
      if (burst_left <= 0) begin
         r = $urandom_range(0, 9);
         if (r < 6) idle_sender($urandom_range(1, 4));
         else if (r < 9) idle_sender($urandom_range(5, 12));
         else idle_sender($urandom_range(13, 30));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 64)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic send_word(input logic [31:0] word, input logic typed,
                            input rvid_result_type want);
      start          <= 1'b1;
      req_instr_word <= word;
      do @(posedge clock); while (busy !== 1'b0);
      expected_decodes.push_back(typed ? want : decode_word(word));
      pace_sender();
   endtask

   always @(posedge clock) begin
      rvid_result_type got;
      if (!reset) begin
         if ((start && busy === 1'b0) || rsp_valid === 1'b1) quiet_cycles = 0;
         else quiet_cycles++;
         if ($isunknown(rsp_valid)) begin
            error_count++;
            if (error_count <= MaxReported) $display("Result strobe is unknown");
         end else if (rsp_valid) begin
            got = '{rsp_op_class, rsp_illegal, rsp_dest_index, rsp_writes_dest,
                    rsp_src1_index, rsp_reads_src1, rsp_src2_index, rsp_reads_src2,
                    rsp_immediate, rsp_ends_block};
            if (expected_decodes.size() == 0) begin
               error_count++;
               if (error_count <= MaxReported)
                  $display("Unexpected result beat: op_class %0d", got.op_class);
            end else begin
               compare_decode(expected_decodes.pop_front(), got);
            end
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] w;
      logic        neg;
      // Words whose result reads straight off the encoding.
      directed_rows.push_back('{32'h0000_0000, 1'b1,
         '{OpLui, 1'b1, 5'd0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 32'sd0, 1'b0}});
      directed_rows.push_back('{32'hFFFF_FFFF, 1'b1,
         '{OpLui, 1'b1, 5'd31, 1'b0, 5'd31, 1'b0, 5'd31, 1'b0, 32'sd0, 1'b0}});
      directed_rows.push_back('{{25'd0, OpcSystem}, 1'b1,
         '{OpLui, 1'b1, 5'd0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 32'sd0, 1'b1}});
      directed_rows.push_back('{{25'd0, OpcMiscMem}, 1'b1,
         '{OpLui, 1'b1, 5'd0, 1'b0, 5'd0, 1'b0, 5'd0, 1'b0, 32'sd0, 1'b0}});
      directed_rows.push_back('{{7'h00, 5'd0, 5'd1, 3'd1, 5'd1, OpcJalr}, 1'b1,
         '{OpLui, 1'b1, 5'd1, 1'b0, 5'd1, 1'b0, 5'd0, 1'b0, 32'sd0, 1'b1}});
      directed_rows.push_back('{{7'h00, 5'd2, 5'd1, 3'd2, 5'd0, OpcBranch}, 1'b1,
         '{OpLui, 1'b1, 5'd0, 1'b0, 5'd1, 1'b0, 5'd2, 1'b0, 32'sd0, 1'b1}});
      directed_rows.push_back('{{20'hFFFFF, 5'd0, OpcLui}, 1'b1,
         '{OpLui, 1'b0, 5'd0, 1'b1, 5'd31, 1'b0, 5'd31, 1'b0, 32'hFFFF_F000, 1'b0}});
      directed_rows.push_back('{{20'h80000, 5'd31, OpcAuipc}, 1'b0, '0});
      directed_rows.push_back('{{1'b1, 19'h0, 5'd1, OpcJal}, 1'b0, '0});
      directed_rows.push_back('{{1'b0, 19'h7FFFF, 5'd31, OpcJal}, 1'b0, '0});
      directed_rows.push_back('{{12'h800, 5'd31, 3'd0, 5'd1, OpcJalr}, 1'b0, '0});
      for (int f = 0; f < 8; f++) begin
         neg = f[0];
         w = {neg ? 7'h7F : 7'h00, 5'(3 * f), 5'(31 - f), 3'(f), 5'(f), OpcBranch};
         directed_rows.push_back('{w, 1'b0, '0});
         w[6:0] = OpcLoad;
         directed_rows.push_back('{w, 1'b0, '0});
         w[6:0] = OpcStore;
         directed_rows.push_back('{w, 1'b0, '0});
         directed_rows.push_back('{{F7Zero, 5'(f), 5'(f), 3'(f), 5'(31 - f), OpcOpImm},
                                   1'b0, '0});
         directed_rows.push_back('{{F7Alt, 5'(f), 5'(f), 3'(f), 5'(31 - f), OpcOpImm},
                                   1'b0, '0});
         directed_rows.push_back('{{F7Zero, 5'(31 - f), 5'(f), 3'(f), 5'(f), OpcOp},
                                   1'b0, '0});
         directed_rows.push_back('{{F7Alt, 5'(31 - f), 5'(f), 3'(f), 5'(f), OpcOp},
                                   1'b0, '0});
      end
      directed_rows.push_back('{{7'h01, 5'd3, 5'd2, 3'd0, 5'd1, OpcOp}, 1'b0, '0});

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 12);
      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      repeat (RandomWords) send_word(random_instruction(), 1'b0, '0);
      start <= 1'b0;
      while (expected_decodes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: rv32i_instruction_decoder.f
+incdir+src
src/rvid_pkg.sv
src/rvid_decode.sv
src/rv32i_instruction_decoder.sv
tb/sv/rv32i_instruction_decoder_tb.sv
